[design/alkvc_pkg.sv]
// Shared types, sizes and helpers of the LRU key/value cache.
package alkvc_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned KeyBytes = 8;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned ValW     = 32;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned RankW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned EntryW   = KeyW + ValW;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [RankW-1:0] rank_t;
  typedef logic [KeyW-1:0]  key_t;
  typedef logic [ValW-1:0]  val_t;

  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

  // Update request for the recency table
  typedef struct packed {
    logic  touch;     // make slot the most recent and mark it valid
    logic  drop;      // invalidate slot
    logic  fresh;     // new entry in an empty or evicted slot: every other valid slot ages
    slot_t slot;
    rank_t old_rank;  // previous rank of a hit slot
  } rank_cmd_t;

  // Keep the low key bytes up to the first zero byte
  function automatic key_t norm_key(input key_t raw);
    key_t acc;
    logic live;
    acc  = '0;
    live = 1'b1;
    for (int b = 0; b < KeyBytes; b++) begin
      if (raw[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) acc[8*b +: 8] = raw[8*b +: 8];
    end
    return acc;
  endfunction

endpackage

[design/alkvc_if.sv]
// Request and response channel interfaces of the LRU key/value cache.
interface alkvc_req_if
  import alkvc_pkg::*;
  ();
  logic valid;
  logic ready;
  logic op;
  key_t key;
  val_t value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink (input valid, input op, input key, input value, output ready);
endinterface

interface alkvc_rsp_if
  import alkvc_pkg::*;
  ();
  logic valid;
  logic ready;
  logic hit;
  val_t data;

  modport source (output valid, output hit, output data, input ready);
  modport sink (input valid, input hit, input data, output ready);
endinterface

[design/assoc_lru_key_value_cache_unit.sv]
// Top level of the fully associative LRU key/value cache.
//
//   channel | dir | payload             | accepted when
//   req_i   | in  | op, key, value      | req_i.valid && req_i.ready
//   rsp_o   | out | hit, data           | rsp_o.valid && rsp_o.ready
//
// Each item passes through an idle state that accepts it, a scan that streams the
// 16 key/value entries out of the RAM (one read per cycle, registered read data),
// then a decide state that writes back at most one entry and updates the ranks.
// Reset clears all valid bits and ranks at once; RAM contents need no clearing.
// A response waiting in the output register does not block the next item;
// the decide cycle holds only while the previous response is still waiting.
module assoc_lru_key_value_cache_unit
  import alkvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  alkvc_req_if.sink   req_i,
  alkvc_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDecide
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_m1;
  logic            rsp_valid_q, rsp_hit_q;
  val_t            rsp_data_q;

  logic  op_q;
  key_t  key_q;
  val_t  val_q;
  logic  match_found_q, empty_found_q, vict_found_q;
  slot_t match_q, empty_q, vict_q;
  rank_t mrank_q, vrank_q;
  val_t  mval_q;

  logic              accept, go, key_zero, cmp_en, ram_re, ram_we;
  slot_t             cmp_idx, wslot;
  logic [EntryW-1:0] rdata;
  key_t              rd_key;
  val_t              rd_val;
  logic              rd_valid;
  rank_t             rd_rank;
  rank_cmd_t         cmd;
  logic              res_hit;
  val_t              res_data;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign go          = (state_q == StDecide) && (!rsp_valid_q || rsp_o.ready);
  assign key_zero    = (key_q == '0);

  // Scan addressing: issue read at cnt, compare entry cnt-1
  assign cnt_m1  = cnt_q - CntW'(1);
  assign cmp_idx = cnt_m1[SlotW-1:0];
  assign cmp_en  = (state_q == StScan) && (cnt_q != '0);
  assign ram_re  = (state_q == StScan) && (cnt_q < CntW'(Capacity));
  assign rd_key  = rdata[EntryW-1 -: KeyW];
  assign rd_val  = rdata[ValW-1:0];

  alkvc_ram #(
    .Width (EntryW),
    .Depth (Capacity)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot),
    .wdata_i ({key_q, val_q}),
    .re_i    (ram_re),
    .raddr_i (cnt_q[SlotW-1:0]),
    .rdata_o (rdata)
  );

  alkvc_recency u_recency (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_slot_i  (cmp_idx),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank)
  );

  // Decide the outcome from the scan results
  always_comb begin
    cmd      = '0;
    ram_we   = 1'b0;
    wslot    = match_q;
    res_hit  = 1'b0;
    res_data = '0;
    if (match_found_q) begin
      res_hit      = 1'b1;
      cmd.touch    = go;
      cmd.slot     = match_q;
      cmd.old_rank = mrank_q;
      if (op_q == OpGet) res_data = mval_q;
      else ram_we = go;
    end else if (op_q == OpPut) begin
      if (empty_found_q) begin
        wslot     = empty_q;
        cmd.slot  = empty_q;
        cmd.fresh = 1'b1;
        cmd.touch = go && !key_zero;
        ram_we    = go && !key_zero;
      end else begin
        wslot     = vict_q;
        cmd.slot  = vict_q;
        cmd.fresh = 1'b1;
        cmd.drop  = go && key_zero;
        cmd.touch = go && !key_zero;
        ram_we    = go && !key_zero;
      end
    end
  end

  // Latch the item and track match, empty slot and oldest slot during the scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q          <= req_i.op;
      key_q         <= norm_key(req_i.key);
      val_q         <= req_i.value;
      match_found_q <= 1'b0;
      empty_found_q <= 1'b0;
      vict_found_q  <= 1'b0;
    end else if (cmp_en) begin
      if (rd_valid) begin
        if (!key_zero && !match_found_q && (rd_key == key_q)) begin
          match_found_q <= 1'b1;
          match_q       <= cmp_idx;
          mrank_q       <= rd_rank;
          mval_q        <= rd_val;
        end
        if (!vict_found_q || (rd_rank > vrank_q)) begin
          vict_found_q <= 1'b1;
          vict_q       <= cmp_idx;
          vrank_q      <= rd_rank;
        end
      end else if (!empty_found_q) begin
        empty_found_q <= 1'b1;
        empty_q       <= cmp_idx;
      end
    end
  end

  // Sequence the scan and hold the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_hit_q   <= 1'b0;
      rsp_data_q  <= '0;
    end else begin
      // Raise the response on a decision, drop it once taken
      if (go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            state_q <= StScan;
            cnt_q   <= '0;
          end
        end
        StScan: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(Capacity)) state_q <= StDecide;
        end
        StDecide: begin
          if (go) begin
            state_q    <= StIdle;
            rsp_hit_q  <= res_hit;
            rsp_data_q <= res_data;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit   = rsp_hit_q;
  assign rsp_o.data  = rsp_data_q;

endmodule

[design/alkvc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module alkvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/alkvc_recency.sv]
// Valid bits and recency ranks of all slots, with the LRU aging update.
module alkvc_recency
  import alkvc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rank_cmd_t cmd_i,
  input  slot_t     rd_slot_i,
  output logic      rd_valid_o,
  output rank_t     rd_rank_o
);

  logic [Capacity-1:0] valid_q;
  rank_t               rank_q [Capacity];

  // Age the more recent slots (all other valid slots on a fresh entry), promote or drop the addressed one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < Capacity; i++) rank_q[i] <= '0;
    end else if (cmd_i.touch) begin
      for (int i = 0; i < Capacity; i++) begin
        if (slot_t'(i) == cmd_i.slot) begin
          valid_q[i] <= 1'b1;
          rank_q[i]  <= '0;
        end else if (valid_q[i] && (cmd_i.fresh || (rank_q[i] < cmd_i.old_rank))) begin
          rank_q[i]  <= rank_q[i] + rank_t'(1);
        end
      end
    end else if (cmd_i.drop) begin
      valid_q[cmd_i.slot] <= 1'b0;
      rank_q[cmd_i.slot]  <= '0;
    end
  end

  assign rd_valid_o = valid_q[rd_slot_i];
  assign rd_rank_o  = rank_q[rd_slot_i];

endmodule

[design/alkvc_chk.sv]
// Port-level checker of the LRU key/value cache, bound to the top level.
module alkvc_chk
  import alkvc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_hit_i,
  input val_t rsp_data_i
);

  logic [1:0] pend_q;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // Count items accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i) && $stable(rsp_hit_i))
    else $error("response changed while stalled");

  a_rsp_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response without an outstanding item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> pend_q != 2'd2)
    else $error("more than two items in flight");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_data_i == '0)
    else $error("miss returned nonzero data");

  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("new item taken while scan in progress");

endmodule

bind assoc_lru_key_value_cache_unit alkvc_chk u_alkvc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_hit_i   (rsp_o.hit),
  .rsp_data_i  (rsp_o.data)
);

[bench/alkvc_lru_checker.sv]
// Checker for the LRU key/value cache: it predicts every response and compares it.
module alkvc_lru_checker
  import alkvc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  alkvc_req_if req_i,
  alkvc_rsp_if rsp_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic hit;
    val_t data;
  } lookup_result_t;

  // Expected responses, oldest first
  lookup_result_t lookup_result_q[$];

  // Shadow copy of the cache contents and recency ranks
  logic  shadow_valid[Capacity];
  key_t  shadow_key[Capacity];
  val_t  shadow_value[Capacity];
  rank_t shadow_rank[Capacity];

  // Keep the low key bytes up to the first zero byte
  function automatic key_t trim_key(input key_t raw);
    key_t acc;
    logic live;
    acc  = '0;
    live = 1'b1;
    for (int b = 0; b < KeyBytes; b++) begin
      if (raw[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) acc[8*b +: 8] = raw[8*b +: 8];
    end
    return acc;
  endfunction

  // Make slot s the most recent; every valid slot newer than older_than ages
  task automatic promote_slot(input int s, input int older_than);
    for (int i = 0; i < Capacity; i++) begin
      if (i != s && shadow_valid[i] && int'(shadow_rank[i]) < older_than)
        shadow_rank[i] = shadow_rank[i] + 1'b1;
    end
    shadow_rank[s] = '0;
  endtask

  // Apply one access to the shadow cache and work out its response
  task automatic predict_access(input logic op, input key_t raw, input val_t value,
                                output lookup_result_t res);
    key_t k;
    int   match;
    int   empty;
    int   victim;
    int   vrank;
    k      = trim_key(raw);
    match  = -1;
    empty  = -1;
    victim = -1;
    vrank  = 0;
    res    = '0;

    // Scan for a match, the first free slot and the oldest entry
    for (int i = 0; i < Capacity; i++) begin
      if (shadow_valid[i]) begin
        if (k != '0 && match < 0 && shadow_key[i] == k) match = i;
        if (victim < 0 || int'(shadow_rank[i]) > vrank) begin
          victim = i;
          vrank  = int'(shadow_rank[i]);
        end
      end else if (empty < 0) begin
        empty = i;
      end
    end

    if (match >= 0) begin
      res.hit = 1'b1;
      if (op == OpGet) res.data = shadow_value[match];
      else shadow_value[match] = value;
      promote_slot(match, int'(shadow_rank[match]));
    end else if (op == OpPut) begin
      if (empty >= 0) begin
        // An empty key with room left changes nothing
        if (k != '0) begin
          shadow_valid[empty] = 1'b1;
          shadow_key[empty]   = k;
          shadow_value[empty] = value;
          promote_slot(empty, Capacity);
        end
      end else if (victim >= 0) begin
        if (k == '0) begin
          // Empty key into a full cache drops the oldest entry
          shadow_valid[victim] = 1'b0;
          shadow_rank[victim]  = '0;
        end else begin
          shadow_key[victim]   = k;
          shadow_value[victim] = value;
          promote_slot(victim, Capacity);
        end
      end
    end
  endtask

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    mismatches_o = mismatches_o + 1;
  endtask

  // Check the response side first, then predict the newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    lookup_result_t fresh;
    if (!rst_ni) begin
      lookup_result_q.delete();
      for (int i = 0; i < Capacity; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_key[i]   = '0;
        shadow_value[i] = '0;
        shadow_rank[i]  = '0;
      end
      mismatches_o = 0;
      pending_o    = 0;
      hits_o       = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (lookup_result_q.size() == 0) begin
          report_mismatch("response with nothing expected", '0, {rsp_i.hit, rsp_i.data});
        end else begin
          want = lookup_result_q.pop_front();
          if (rsp_i.hit !== want.hit) report_mismatch("hit", want.hit, rsp_i.hit);
          if (rsp_i.data !== want.data) report_mismatch("data", want.data, rsp_i.data);
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_access(req_i.op, req_i.key, req_i.value, fresh);
        if (fresh.hit) hits_o = hits_o + 1;
        lookup_result_q.push_back(fresh);
      end
      pending_o = lookup_result_q.size();
    end
  end

endmodule

[bench/assoc_lru_key_value_cache_unit_tb.sv]
// Testbench top for the LRU key/value cache: stimulus, response stalls and verdict.
module assoc_lru_key_value_cache_unit_tb;
  import alkvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PoolSize   = 24;
  localparam int CycleLimit = 300000;
  localparam int StallLen   = 400;
  localparam int DrainWait  = 60;

  logic clk_i;
  logic rst_ni;

  alkvc_req_if req_ch ();
  alkvc_rsp_if rsp_ch ();

  int mismatches;
  int pending;
  int hits;

  int tx_idle_pct;
  int rx_idle_pct;
  bit stall_req;
  bit stall_done;
  int stall_left;
  int cycle_count;
  int n_puts;
  int n_gets;

  key_t pool_key[PoolSize];
  int   pool_len[PoolSize];

  assoc_lru_key_value_cache_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  alkvc_lru_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .hits_o       (hits)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side: random back-pressure, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        stall_left = StallLen;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item and hold it until it is accepted
  task automatic send_req(input op_e op, input key_t key, input val_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= key;
    req_ch.value <= value;
    if (op == OpPut) n_puts++;
    else n_gets++;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // Pool key, sometimes with junk bytes after its terminating zero byte
  function automatic key_t dressed_key(input int idx);
    key_t junk;
    int   len;
    len  = pool_len[idx];
    junk = {$urandom, $urandom};
    if (len <= 6 && $urandom_range(1) == 1)
      return pool_key[idx] | (junk & ~((64'h1 << (8 * (len + 1))) - 64'h1));
    return pool_key[idx];
  endfunction

  // Key whose low byte is zero, with random upper bytes
  function automatic key_t empty_key();
    return {$urandom, $urandom} & ~64'hFF;
  endfunction

  // Mostly gets and puts on a small key pool, with some empty and random keys
  task automatic random_req(input int pool_lim);
    int r;
    int idx;
    r   = $urandom_range(99);
    idx = $urandom_range(pool_lim - 1);
    if (r < 44) send_req(OpGet, dressed_key(idx), $urandom);
    else if (r < 88) send_req(OpPut, dressed_key(idx), $urandom);
    else if (r < 94) send_req(OpPut, empty_key(), $urandom);
    else if (r < 97) send_req(OpGet, empty_key(), $urandom);
    else send_req(op_e'($urandom_range(1)), {$urandom, $urandom}, $urandom);
  endtask

  initial begin
    int len;
    key_t k;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op    = OpGet;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    tx_idle_pct  = 19;
    rx_idle_pct  = 64;
    stall_req    = 1'b0;
    stall_done   = 1'b0;
    stall_left   = 0;
    cycle_count  = 0;
    n_puts       = 0;
    n_gets       = 0;

    // Build the key pool: 1 to 8 nonzero bytes each
    for (int i = 0; i < PoolSize; i++) begin
      len = $urandom_range(8, 1);
      k   = '0;
      for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(255, 1));
      pool_key[i] = k;
      pool_len[i] = len;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme key and values, hit and miss, update, empty keys
    send_req(OpPut, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OpGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_req(OpGet, 64'h0000_0000_0000_0001, 32'h0);
    send_req(OpPut, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_req(OpGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OpGet, 64'hFFFF_FFFF_FFFF_FF00, 32'h0);
    send_req(OpPut, 64'hFFFF_FFFF_FFFF_FF00, 32'h1234_5678);
    // Junk after the zero byte must be ignored
    send_req(OpPut, 64'hDEAD_BEEF_CA00_0041, 32'hA5A5_5A5A);
    send_req(OpGet, 64'h0000_0000_0000_0041, 32'h0);
    // Fill the remaining slots, then evict and drop the oldest entry
    for (int i = 0; i < 14; i++) send_req(OpPut, 64'h100 | key_t'(i + 1), 32'(i));
    send_req(OpPut, 64'h0000_0000_0000_7777, 32'h0BAD_F00D);
    send_req(OpPut, 64'h0123_4567_89AB_CD00, 32'hFFFF_FFFF);

    // Random, first mix: sparse sender gaps, heavy response stalls
    for (int i = 0; i < 130; i++) random_req(PoolSize);

    // Random, second mix: the other way round, small pool with few evictions
    tx_idle_pct = 64;
    rx_idle_pct = 19;
    for (int i = 0; i < 130; i++) random_req(($urandom_range(1) == 1) ? 12 : PoolSize);

    // Random, no idling; one long response hold-off fills the block
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_req   = 1'b1;
    for (int i = 0; i < 140; i++) random_req(PoolSize);
    req_ch.valid <= 1'b0;

    // Drain outstanding responses, then let the block settle
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d requests (%0d puts, %0d gets) with %0d hits over three idle mixes",
             n_puts + n_gets, n_puts, n_gets, hits);
    $display("plus a %0d-cycle response hold-off; %0d mismatches", StallLen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/alkvc_pkg.sv
design/alkvc_if.sv
design/alkvc_ram.sv
design/alkvc_recency.sv
design/assoc_lru_key_value_cache_unit.sv
design/alkvc_chk.sv
bench/alkvc_lru_checker.sv
bench/assoc_lru_key_value_cache_unit_tb.sv
